// ----- design/prac_pkg.sv -----
// Shared types, constants and the per-degree sine table for the point rotator.
`default_nettype none

package prac_pkg;

  // Fraction bits of the sine and cosine factors (Q1.16).
  localparam int TRIG_FRAC_BITS = 16;
  // Signed width that holds -1.0 .. +1.0 in that format.
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_W = 9;
  localparam int CFG_IDX_W = 2;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 2'd2;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } trig_t;

  // round(sin(d degrees) * 2^16) for d in 0..90
  function automatic logic [TRIG_FRAC_BITS:0] sin_quarter(input logic [6:0] d);
    logic [TRIG_FRAC_BITS:0] v;
    case (d)
      7'd0:  v = 17'd0;
      7'd1:  v = 17'd1144;
      7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;
      7'd4:  v = 17'd4572;
      7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;
      7'd7:  v = 17'd7987;
      7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252;
      7'd10: v = 17'd11380;
      7'd11: v = 17'd12505;
      7'd12: v = 17'd13626;
      7'd13: v = 17'd14742;
      7'd14: v = 17'd15855;
      7'd15: v = 17'd16962;
      7'd16: v = 17'd18064;
      7'd17: v = 17'd19161;
      7'd18: v = 17'd20252;
      7'd19: v = 17'd21336;
      7'd20: v = 17'd22415;
      7'd21: v = 17'd23486;
      7'd22: v = 17'd24550;
      7'd23: v = 17'd25607;
      7'd24: v = 17'd26656;
      7'd25: v = 17'd27697;
      7'd26: v = 17'd28729;
      7'd27: v = 17'd29753;
      7'd28: v = 17'd30767;
      7'd29: v = 17'd31772;
      7'd30: v = 17'd32768;
      7'd31: v = 17'd33754;
      7'd32: v = 17'd34729;
      7'd33: v = 17'd35693;
      7'd34: v = 17'd36647;
      7'd35: v = 17'd37590;
      7'd36: v = 17'd38521;
      7'd37: v = 17'd39441;
      7'd38: v = 17'd40348;
      7'd39: v = 17'd41243;
      7'd40: v = 17'd42126;
      7'd41: v = 17'd42995;
      7'd42: v = 17'd43852;
      7'd43: v = 17'd44695;
      7'd44: v = 17'd45525;
      7'd45: v = 17'd46341;
      7'd46: v = 17'd47143;
      7'd47: v = 17'd47930;
      7'd48: v = 17'd48703;
      7'd49: v = 17'd49461;
      7'd50: v = 17'd50203;
      7'd51: v = 17'd50931;
      7'd52: v = 17'd51643;
      7'd53: v = 17'd52339;
      7'd54: v = 17'd53020;
      7'd55: v = 17'd53684;
      7'd56: v = 17'd54332;
      7'd57: v = 17'd54963;
      7'd58: v = 17'd55578;
      7'd59: v = 17'd56175;
      7'd60: v = 17'd56756;
      7'd61: v = 17'd57319;
      7'd62: v = 17'd57865;
      7'd63: v = 17'd58393;
      7'd64: v = 17'd58903;
      7'd65: v = 17'd59396;
      7'd66: v = 17'd59870;
      7'd67: v = 17'd60326;
      7'd68: v = 17'd60764;
      7'd69: v = 17'd61183;
      7'd70: v = 17'd61584;
      7'd71: v = 17'd61966;
      7'd72: v = 17'd62328;
      7'd73: v = 17'd62672;
      7'd74: v = 17'd62997;
      7'd75: v = 17'd63303;
      7'd76: v = 17'd63589;
      7'd77: v = 17'd63856;
      7'd78: v = 17'd64104;
      7'd79: v = 17'd64332;
      7'd80: v = 17'd64540;
      7'd81: v = 17'd64729;
      7'd82: v = 17'd64898;
      7'd83: v = 17'd65048;
      7'd84: v = 17'd65177;
      7'd85: v = 17'd65287;
      7'd86: v = 17'd65376;
      7'd87: v = 17'd65446;
      7'd88: v = 17'd65496;
      7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Fold an angle of 0..511 degrees back into 0..359.
  function automatic logic [ANGLE_W-1:0] wrap_deg(input logic [ANGLE_W-1:0] a);
    return (a >= DEG_360) ? (a - DEG_360) : a;
  endfunction

  // Signed sine of an angle already in 0..359, by quadrant symmetry.
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [ANGLE_W-1:0] a);
    logic [ANGLE_W-1:0] q;
    logic neg;
    logic signed [TRIG_W-1:0] mag;
    if (a <= DEG_90) begin
      q = a;
      neg = 1'b0;
    end else if (a <= DEG_180) begin
      q = DEG_180 - a;
      neg = 1'b0;
    end else if (a <= DEG_270) begin
      q = a - DEG_180;
      neg = 1'b1;
    end else begin
      q = DEG_360 - a;
      neg = 1'b1;
    end
    mag = $signed({1'b0, sin_quarter(q[6:0])});
    return neg ? -mag : mag;
  endfunction

endpackage

`default_nettype wire

// ----- design/prac_cfg.sv -----
// Configuration registers: rotation centre and sine/cosine of the angle.
`default_nettype none

module prac_cfg #(
  parameter int COORD_BITS = 16,
  parameter int CFG_W = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [prac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_W-1:0]                  cfg_wdata,
  output logic signed [COORD_BITS-1:0]     center_x,
  output logic signed [COORD_BITS-1:0]     center_y,
  output prac_pkg::trig_t                  trig
);

  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;
  prac_pkg::trig_t              trig_r, trig_nxt;
  logic [prac_pkg::ANGLE_W-1:0] ang;
  logic [prac_pkg::ANGLE_W-1:0] ang_cos;

  // Look the factors up at write time; the datapath only sees registers.
  always_comb begin
    ang     = prac_pkg::wrap_deg(cfg_wdata[prac_pkg::ANGLE_W-1:0]);
    ang_cos = prac_pkg::wrap_deg(ang + prac_pkg::DEG_90);
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    trig_nxt = trig_r;
    if (cfg_we) begin
      case (cfg_index)
        prac_pkg::REG_CENTER_X: cx_nxt = $signed(cfg_wdata[COORD_BITS-1:0]);
        prac_pkg::REG_CENTER_Y: cy_nxt = $signed(cfg_wdata[COORD_BITS-1:0]);
        prac_pkg::REG_ANGLE: begin
          trig_nxt.sin_v = prac_pkg::sin_deg(ang);
          trig_nxt.cos_v = prac_pkg::sin_deg(ang_cos);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r         <= '0;
      cy_r         <= '0;
      trig_r.sin_v <= '0;
      trig_r.cos_v <= prac_pkg::TRIG_ONE;
    end else begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      trig_r <= trig_nxt;
    end
  end

  assign center_x = cx_r;
  assign center_y = cy_r;
  assign trig     = trig_r;

endmodule

`default_nettype wire

// ----- design/prac_core.sv -----
// Rotation datapath: input register, one multiply-add pass, result register.
`default_nettype none

module prac_core #(
  parameter int COORD_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_vld,
  input  wire signed [COORD_BITS-1:0]  in_px,
  input  wire signed [COORD_BITS-1:0]  in_py,
  input  wire signed [COORD_BITS-1:0]  center_x,
  input  wire signed [COORD_BITS-1:0]  center_y,
  input  prac_pkg::trig_t              trig,
  output logic                         out_vld,
  output logic signed [COORD_BITS-1:0] out_rx,
  output logic signed [COORD_BITS-1:0] out_ry,
  output logic                         out_sat
);

  localparam int TF = prac_pkg::TRIG_FRAC_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + prac_pkg::TRIG_W;
  localparam int SW = PW + 1;
  localparam int QW = SW - TF;
  localparam int RW = QW + 1;

  logic                         vld_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                         ovld_r;
  logic signed [COORD_BITS-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic                         sat_r, sat_nxt;

  logic signed [DW-1:0] dx, dy;
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [QW-1:0] q_x, q_y;
  logic signed [RW-1:0] r_x, r_y;
  logic                 sat_x, sat_y;

  // Divide by 2^TF, rounding toward zero.
  function automatic logic signed [QW-1:0] trunc_q(input logic signed [SW-1:0] s);
    logic rnd;
    rnd = s[SW-1] & (|s[TF-1:0]);
    return $signed(s[SW-1:TF]) + $signed({{(QW-1){1'b0}}, rnd});
  endfunction

  // Clamp to the coordinate range; top bit of the result flags a clamp.
  function automatic logic [COORD_BITS:0] clamp_c(input logic signed [RW-1:0] r);
    logic ovf;
    logic [COORD_BITS-1:0] v;
    ovf = !((&r[RW-1:COORD_BITS-1]) || !(|r[RW-1:COORD_BITS-1]));
    if (!ovf) begin
      v = r[COORD_BITS-1:0];
    end else if (r[RW-1]) begin
      v = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      v = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return {ovf, v};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= in_vld;
      ovld_r <= vld_r;
    end
  end

  // Hold the point on accept.
  always_ff @(posedge clk) begin
    if (in_vld) begin
      px_r <= in_px;
      py_r <= in_py;
    end
  end

  always_comb begin
    dx    = $signed({px_r[COORD_BITS-1], px_r}) - $signed({center_x[COORD_BITS-1], center_x});
    dy    = $signed({py_r[COORD_BITS-1], py_r}) - $signed({center_y[COORD_BITS-1], center_y});
    p_xc  = dx * trig.cos_v;
    p_ys  = dy * trig.sin_v;
    p_xs  = dx * trig.sin_v;
    p_yc  = dy * trig.cos_v;
    sum_x = $signed({p_xc[PW-1], p_xc}) - $signed({p_ys[PW-1], p_ys});
    sum_y = $signed({p_xs[PW-1], p_xs}) + $signed({p_yc[PW-1], p_yc});
    q_x   = trunc_q(sum_x);
    q_y   = trunc_q(sum_y);
    r_x   = $signed({q_x[QW-1], q_x})
          + $signed({{(RW-COORD_BITS){center_x[COORD_BITS-1]}}, center_x});
    r_y   = $signed({q_y[QW-1], q_y})
          + $signed({{(RW-COORD_BITS){center_y[COORD_BITS-1]}}, center_y});
    {sat_x, rx_nxt} = clamp_c(r_x);
    {sat_y, ry_nxt} = clamp_c(r_y);
    sat_nxt = sat_x | sat_y;
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_vld = ovld_r;
  assign out_rx  = rx_r;
  assign out_ry  = ry_r;
  assign out_sat = sat_r;

endmodule

`default_nettype wire

// ----- design/point_rotate_about_center.sv -----
// Top level of the point rotator: configuration port plus rotation datapath.
// Path: a point taken into the input register is rotated into the result register,
//   which raises out_strobe for a single cycle.
// Throughput: one point per clock; busy is never raised. The figure is set by the
//   single register-to-register pass holding four parallel 17x18 multipliers.
// Reset (synchronous, rst_n low): centre cleared to (0, 0), angle to 0, no result
//   in flight. The receiver cannot stall; every result is shown exactly once.
`default_nettype none

module point_rotate_about_center #(
  parameter int COORD_BITS = 16
) (
  input  wire                                               clk,
  input  wire                                               rst_n,
  // item channel
  input  wire                                               start,
  output logic                                              busy,
  input  wire signed [COORD_BITS-1:0]                       in_point_x,
  input  wire signed [COORD_BITS-1:0]                       in_point_y,
  // configuration write port
  input  wire                                               cfg_we,
  input  wire [prac_pkg::CFG_IDX_W-1:0]                     cfg_index,
  input  wire [((COORD_BITS > prac_pkg::ANGLE_W) ? COORD_BITS
                : prac_pkg::ANGLE_W)-1:0]                   cfg_wdata,
  // result channel
  output logic                                              out_strobe,
  output logic signed [COORD_BITS-1:0]                      out_rotated_x,
  output logic signed [COORD_BITS-1:0]                      out_rotated_y,
  output logic                                              out_saturated
);

  // Data word must carry both a coordinate and a 9-bit angle.
  localparam int CFG_W = (COORD_BITS > prac_pkg::ANGLE_W) ? COORD_BITS : prac_pkg::ANGLE_W;

  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  prac_pkg::trig_t              trig;
  logic                         accept;

  // The pass is fully pipelined, so a beat is taken every cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Centre and angle registers; sine and cosine are resolved on the write
  // itself so the datapath never waits on the table.
  prac_cfg #(
    .COORD_BITS (COORD_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .center_x  (center_x),
    .center_y  (center_y),
    .trig      (trig)
  );

  // Register the point, rotate its offset, truncate toward zero, add the
  // centre back and clamp; the result register drives the strobe.
  prac_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (accept),
    .in_px    (in_point_x),
    .in_py    (in_point_y),
    .center_x (center_x),
    .center_y (center_y),
    .trig     (trig),
    .out_vld  (out_strobe),
    .out_rx   (out_rotated_x),
    .out_ry   (out_rotated_y),
    .out_sat  (out_saturated)
  );

endmodule

`default_nettype wire

// ----- design/prac_chk.sv -----
// Port-level checker for the point rotator, bound to the top level.
`default_nettype none

module prac_chk #(
  parameter int COORD_BITS = 16
) (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input wire [COORD_BITS-1:0] in_point_x,
  input wire [COORD_BITS-1:0] in_point_y,
  input wire                  cfg_we,
  input wire                  out_strobe,
  input wire [COORD_BITS-1:0] out_rotated_x,
  input wire [COORD_BITS-1:0] out_rotated_y,
  input wire                  out_saturated
);

  localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Every accepted beat yields exactly one result, through the input and result registers.
  a_latency: assert property (@(posedge clk)
    ($past(rst_n) && $past(rst_n, 2)) |-> (out_strobe == $past(start && !busy, 2)))
    else $error("result strobe does not match accepted beat");

  // A clamp flag must come with a coordinate sitting on a range bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |->
      (out_rotated_x == MAXV || out_rotated_x == MINV ||
       out_rotated_y == MAXV || out_rotated_y == MINV))
    else $error("saturated flag without a clamped coordinate");

  // The block keeps no state: equal points under unchanged setup give equal results.
  a_stateless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(out_strobe) && $past(rst_n) && $past(rst_n, 2) &&
     $past(rst_n, 3) && !$past(cfg_we, 2) && !$past(cfg_we, 3) &&
     !$past(cfg_we, 4) &&
     $past(in_point_x, 2) == $past(in_point_x, 3) &&
     $past(in_point_y, 2) == $past(in_point_y, 3)) |->
      ($stable(out_rotated_x) && $stable(out_rotated_y) && $stable(out_saturated)))
    else $error("identical points gave different results");

  // A reset edge leaves no strobe in the cycle that follows it.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe during reset");

endmodule

bind point_rotate_about_center prac_chk #(.COORD_BITS(COORD_BITS)) u_prac_chk (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for point_rotate_about_center: directed and random points.
`timescale 1ns / 100ps

module tb;

  localparam int COORD_BITS = 16;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int RANDOM_PHASES = 11;
  // Quiet cycles tolerated before the run is declared hung: far above the longest
  // sender gap, drain pause and register write sequence put together.
  localparam int STALL_LIMIT = 2000;
  // pi scaled by 2^60, truncated; seed of the sine series
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         sat;
  } rotated_point_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic                         cfg_we = 1'b0;
  logic [prac_pkg::CFG_IDX_W-1:0] cfg_index = prac_pkg::REG_CENTER_X;
  logic [COORD_BITS-1:0]        cfg_wdata = '0;
  logic                         out_strobe;
  logic signed [COORD_BITS-1:0] out_rotated_x;
  logic signed [COORD_BITS-1:0] out_rotated_y;
  logic                         out_saturated;

  // Testbench copy of the geometry registers, updated once the whole write sequence is done.
  logic signed [COORD_BITS-1:0] pivot_x = '0;
  logic signed [COORD_BITS-1:0] pivot_y = '0;
  logic [prac_pkg::ANGLE_W-1:0] turn_deg = '0;

  longint         quarter_sine[0:90];
  rotated_point_t pending_points[$];
  int             mismatches = 0;
  int             quiet_cycles = 0;

  point_rotate_about_center #(.COORD_BITS(COORD_BITS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_strobe   (out_strobe),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sine table, built independently of the design: a Taylor series in Q4.60
  // fixed point, then rounded to nearest at TRIG_FRAC_BITS fraction bits.
  // ---------------------------------------------------------------------------

  // (a * b) >> 60, kept to 64 bits
  function automatic longint unsigned q60_mul(input longint unsigned a, input longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  function automatic longint series_sine(input int deg);
    longint unsigned x, x2, term, total;
    int n;
    x = (PI_Q60 / 64'd180) * longint'(deg);
    x2 = q60_mul(x, x);
    term = x;
    total = x;
    for (n = 1; n < 20 && term != 0; n++) begin
      term = q60_mul(term, x2) / longint'((2 * n) * (2 * n + 1));
      // alternate signs: x - x^3/3! + x^5/5! - ...
      if (n % 2 == 1) total -= term;
      else total += term;
    end
    total += 64'd1 << (59 - prac_pkg::TRIG_FRAC_BITS);
    return longint'(total >> (60 - prac_pkg::TRIG_FRAC_BITS));
  endfunction

  // Signed sine for any whole degree; fold by quadrant onto the 0..90 table.
  function automatic longint sine_of(input int deg);
    int a;
    a = deg % 360;
    if (a <= 90) return quarter_sine[a];
    if (a <= 180) return quarter_sine[180 - a];
    if (a <= 270) return -quarter_sine[a - 180];
    return -quarter_sine[360 - a];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v, inout logic sat);
    longint hi, lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi[COORD_BITS-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Rotate one point about the current pivot. Products are exact; the
  // division truncates toward zero, as signed integer division does.
  function automatic rotated_point_t rotate_point(input logic signed [COORD_BITS-1:0] px,
                                                   input logic signed [COORD_BITS-1:0] py);
    rotated_point_t r;
    longint dx, dy, s, c, qx, qy, unity;
    int a;
    logic sat;
    a = int'(turn_deg) % 360;
    s = sine_of(a);
    c = sine_of(a + 90);
    unity = longint'(1) <<< prac_pkg::TRIG_FRAC_BITS;
    dx = longint'(px) - longint'(pivot_x);
    dy = longint'(py) - longint'(pivot_y);
    qx = (dx * c - dy * s) / unity;
    qy = (dx * s + dy * c) / unity;
    sat = 1'b0;
    r.x = clamp_coord(longint'(pivot_x) + qx, sat);
    r.y = clamp_coord(longint'(pivot_y) + qy, sat);
    r.sat = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting, checking and the hang watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Results are shown for one cycle and cannot be held off: compare every
  // strobed beat against the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    rotated_point_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected result (%0d, %0d) sat=%b",
                                  out_rotated_x, out_rotated_y, out_saturated));
      end else begin
        want = pending_points.pop_front();
        if (out_rotated_x !== want.x)
          report_mismatch($sformatf("rotated_x got %0d, want %0d", out_rotated_x, want.x));
        if (out_rotated_y !== want.y)
          report_mismatch($sformatf("rotated_y got %0d, want %0d", out_rotated_y, want.y));
        if (out_saturated !== want.sat)
          report_mismatch($sformatf("saturated got %b, want %b", out_saturated, want.sat));
      end
    end
  end

  // Count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy !== 1'b1) || out_strobe === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving. Everything is assigned just after a rising edge; start is left
  // high after a beat so that back-to-back points need no re-assertion.
  // ---------------------------------------------------------------------------

  task automatic send_point(input logic signed [COORD_BITS-1:0] px,
                            input logic signed [COORD_BITS-1:0] py);
    start <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    // hold until the edge that takes the beat
    do @(posedge clk); while (busy === 1'b1);
    pending_points.push_back(rotate_point(px, py));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait for every outstanding result, plus a little slack
  // for the two-stage pipeline to go quiet.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges with the block idle.
  task automatic set_geometry(input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy,
                              input logic [COORD_BITS-1:0] angle_word);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= prac_pkg::REG_CENTER_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_index <= prac_pkg::REG_CENTER_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_index <= prac_pkg::REG_ANGLE;
    cfg_wdata <= angle_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    pivot_x = cx;
    pivot_y = cy;
    turn_deg = angle_word[prac_pkg::ANGLE_W-1:0];
  endtask

  // Mostly points near the pivot (non-trivial, rarely clamped), some across the
  // whole range and a few right on the extremes or at 0 and -1.
  function automatic logic signed [COORD_BITS-1:0] random_coord(
      input logic signed [COORD_BITS-1:0] around);
    int pick, v;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else if (pick <= 5) begin
      v = int'(around) + int'($urandom_range(0, 4000)) - 2000;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else begin
      v = $urandom;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry: pivot at the origin, no rotation, so points pass unchanged.
  task automatic test_reset_state();
    send_point(16'sd0, 16'sd0);
    send_point(16'sd32767, -16'sd32768);
    send_point(-16'sd32768, 16'sd32767);
    send_point(-16'sd1, 16'sd1);
  endtask

  // Quarter turns about the origin; the most negative corner overflows.
  task automatic test_right_angles();
    logic [prac_pkg::ANGLE_W-1:0] quarter[3];
    quarter = '{prac_pkg::DEG_90, prac_pkg::DEG_180, prac_pkg::DEG_270};
    foreach (quarter[i]) begin
      set_geometry(16'sd0, 16'sd0, {7'd0, quarter[i]});
      send_point(-16'sd32768, -16'sd32768);
      send_point(16'sd32767, 16'sd12345);
      send_point(16'sd1, -16'sd1);
    end
  endtask

  // Half turns about the corners push points past both bounds.
  task automatic test_saturation();
    set_geometry(16'sd32767, 16'sd32767, {7'd0, prac_pkg::DEG_180});
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    set_geometry(-16'sd32768, -16'sd32768, {7'd0, prac_pkg::DEG_180});
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767);
  endtask

  // Angles near, at and past a full turn fold back modulo 360.
  task automatic test_angle_wrap();
    int angles[4];
    angles = '{359, 360, 450, 511};
    foreach (angles[i]) begin
      set_geometry(16'sd100, -16'sd200, 16'(angles[i]));
      send_point(16'sd3000, 16'sd700);
      send_point(-16'sd2500, -16'sd4321);
    end
  endtask

  // Random phases: each reprograms the geometry, then streams points in bursts.
  task automatic test_random_phases();
    logic signed [COORD_BITS-1:0] cx, cy;
    logic [COORD_BITS-1:0] angle_word;
    int burst_left;
    int corner_angles[7];
    corner_angles = '{0, 90, 180, 270, 359, 360, 511};
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // the first phases pin the pivot and angle to their extremes
      case (phase)
        0: begin cx = -16'sd32768; cy = -16'sd32768; angle_word = 16'd0; end
        1: begin cx = 16'sd32767;  cy = 16'sd32767;  angle_word = 16'd359; end
        2: begin cx = -16'sd32768; cy = 16'sd32767;  angle_word = 16'd511; end
        3: begin cx = 16'sd32767;  cy = -16'sd32768; angle_word = 16'd360; end
        default: begin
          cx = ($urandom_range(0, 3) == 0) ? random_coord(16'sd0) : 16'($urandom);
          cy = ($urandom_range(0, 3) == 0) ? random_coord(16'sd0) : 16'($urandom);
          angle_word = ($urandom_range(0, 3) == 0)
                       ? 16'(corner_angles[$urandom_range(0, 6)])
                       : 16'($urandom_range(0, 511));
        end
      endcase
      // bits above the angle field are don't-care; toggle them anyway
      angle_word[COORD_BITS-1:prac_pkg::ANGLE_W] = 7'($urandom_range(0, 127));
      set_geometry(cx, cy, angle_word);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
          // mostly short bursts, now and then a long unbroken stretch
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                   : $urandom_range(1, 24);
        end
        send_point(random_coord(pivot_x), random_coord(pivot_y));
        burst_left--;
      end
    end
  endtask

  initial begin
    for (int d = 0; d <= 90; d++) quarter_sine[d] = series_sine(d);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_right_angles();
    test_saturation();
    test_angle_wrap();
    test_random_phases();
    drain_results();
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
